[hdl/pds_pkg.sv]
// ---------------------------------------------------------------------------
// pds_pkg
// Shared widths, handshake structs and helpers for the proper divisor sum.
// ---------------------------------------------------------------------------
`default_nettype none

package pds_pkg;

    // width of the incoming number and of the running sum
    localparam int NUMBER_BITS = 20;
    localparam int SUM_BITS    = 22;

    // bit counter of the serial divider, counts 0 .. NUMBER_BITS-1 while busy
    localparam int CNT_BITS    = (NUMBER_BITS > 1) ? $clog2(NUMBER_BITS) : 1;

    // request into the serial divider
    typedef struct packed {
        logic                   start;
        logic [NUMBER_BITS-1:0] dividend;
        logic [NUMBER_BITS-1:0] divisor;
    } div_req_t;

    // response from the serial divider
    typedef struct packed {
        logic                   done;
        logic [NUMBER_BITS-1:0] quotient;
        logic [NUMBER_BITS-1:0] remainder;
    } div_rsp_t;

    // fit a number-wide value into the sum width (extend or wrap)
    function automatic logic [SUM_BITS-1:0] to_sum(input logic [NUMBER_BITS-1:0] v);
        return SUM_BITS'(v);
    endfunction

endpackage

`default_nettype wire

[hdl/proper_divisor_sum.sv]
// ---------------------------------------------------------------------------
// proper_divisor_sum
// Sum of the proper divisors of a number by trial division, one serial
// divide per candidate divisor.
//
//   channel  dir  handshake            fields
//   -------  ---  -------------------  -------------------------
//   in       in   in_valid / in_stall  number [NUMBER_BITS]
//   out      out  out_valid/out_stall  divisor_sum [SUM_BITS]
//
// Candidates d = 2, 3, ... are tried until the quotient n/d drops below d,
// so floor(sqrt(n)) candidates are divided for n >= 2.
// Each candidate is one full divide in the bit-serial divider; 0 and 1
// skip the divider and go straight to the finish state.
// One word is worked on at a time; a finished sum sits in the output
// register, and the next word is taken while it waits. A second finished
// sum holds in the finish state while the output register is full and stalled.
// Reset clears the control state; nothing is kept between words.
// ---------------------------------------------------------------------------
`default_nettype none

module proper_divisor_sum
    import pds_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [NUMBER_BITS-1:0] number,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [SUM_BITS-1:0]         divisor_sum
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAUNCH,
        S_WAIT,
        S_FINISH
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [NUMBER_BITS-1:0] n_reg;
    logic [NUMBER_BITS-1:0] n_next;
    logic [NUMBER_BITS-1:0] d_reg;
    logic [NUMBER_BITS-1:0] d_next;
    logic [SUM_BITS-1:0]    total_reg;
    logic [SUM_BITS-1:0]    total_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SUM_BITS-1:0]    out_sum_reg;
    logic [SUM_BITS-1:0]    out_sum_next;
    logic                   accept;
    logic                   hit;
    logic [SUM_BITS-1:0]    add_d;
    logic [SUM_BITS-1:0]    add_q;
    div_req_t               dv_req;
    div_rsp_t               dv_rsp;

    // serial divider shared by all candidates
    pds_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dv_req),
        .rsp   (dv_rsp)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    assign dv_req.start    = (state_reg == S_LAUNCH);
    assign dv_req.dividend = n_reg;
    assign dv_req.divisor  = d_reg;

    // terms added for a candidate that divides evenly
    always_comb
    begin
        hit   = (dv_rsp.remainder == '0);
        add_d = hit ? to_sum(d_reg) : '0;
        add_q = (hit && (dv_rsp.quotient != d_reg)) ? to_sum(dv_rsp.quotient) : '0;
    end

    // sequencer over candidate divisors
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_sum_next   = out_sum_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    n_next = number;
                    d_next = NUMBER_BITS'(2);
                    if (number < NUMBER_BITS'(2))
                    begin
                        total_next = '0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        total_next = SUM_BITS'(1);
                        state_next = S_LAUNCH;
                    end
                end
            end
            S_LAUNCH:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (dv_rsp.done)
                begin
                    if (dv_rsp.quotient < d_reg)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        total_next = total_reg + add_d + add_q;
                        d_next     = d_reg + NUMBER_BITS'(1);
                        state_next = S_LAUNCH;
                    end
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_sum_next   = total_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and output valid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working data
    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        d_reg       <= d_next;
        total_reg   <= total_next;
        out_sum_reg <= out_sum_next;
    end

    assign out_valid   = out_valid_reg;
    assign divisor_sum = out_sum_reg;

    // divider only answers while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        dv_rsp.done |-> (state_reg == S_WAIT))
        else $error("divider done outside wait state");

    // an accepted word starts a divide or goes straight to the output
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_LAUNCH || state_reg == S_FINISH))
        else $error("accepted word not started");

    // candidates start at two
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LAUNCH) |-> (d_reg >= NUMBER_BITS'(2)))
        else $error("candidate divisor below two");

    // a new output word only comes from the finish state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_FINISH))
        else $error("output word loaded outside finish state");

endmodule

`default_nettype wire

[hdl/pds_divider.sv]
// ---------------------------------------------------------------------------
// pds_divider
// Bit-serial restoring divider: one quotient bit per cycle, the dividend
// shifting out of the quotient register as the quotient shifts in.
// ---------------------------------------------------------------------------
`default_nettype none

module pds_divider
    import pds_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                   busy_reg;
    logic                   busy_next;
    logic                   done_reg;
    logic                   done_next;
    logic [CNT_BITS-1:0]    count_reg;
    logic [CNT_BITS-1:0]    count_next;
    logic [NUMBER_BITS-1:0] rem_reg;
    logic [NUMBER_BITS-1:0] rem_next;
    logic [NUMBER_BITS-1:0] quo_reg;
    logic [NUMBER_BITS-1:0] quo_next;
    logic [NUMBER_BITS-1:0] divisor_reg;
    logic [NUMBER_BITS-1:0] divisor_next;
    logic [NUMBER_BITS:0]   trial;
    logic [NUMBER_BITS:0]   diff;
    logic                   fits;

    // one restoring step: bring down the next dividend bit, try a subtract
    always_comb
    begin
        trial = {rem_reg, quo_reg[NUMBER_BITS-1]};
        diff  = trial - {1'b0, divisor_reg};
        fits  = (trial >= {1'b0, divisor_reg});
    end

    // next state of the shift registers and counter
    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (busy_reg)
        begin
            rem_next   = fits ? diff[NUMBER_BITS-1:0] : trial[NUMBER_BITS-1:0];
            quo_next   = {quo_reg[NUMBER_BITS-2:0], fits};
            count_next = count_reg + CNT_BITS'(1);
            if (count_reg == CNT_BITS'(NUMBER_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next    = 1'b1;
            count_next   = '0;
            rem_next     = '0;
            quo_next     = req.dividend;
            divisor_next = req.divisor;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // data shift registers
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

[tb/tb_proper_divisor_sum.sv]
// ---------------------------------------------------------------------------
// tb_proper_divisor_sum
// Self-checking bench for the proper divisor sum block. Every accepted
// number gets its expected sum of proper divisors, which is computed by
// trial division in the bench. Each sum word that leaves the block is
// compared in order against that expectation. Stimulus is a directed set
// of edge values followed by random numbers, mostly small ones. The random
// numbers run under three idle mixes on both channels, and there is one
// long output hold-off that backs the block up into its input.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_proper_divisor_sum;

    import pds_pkg::*;

    // cycles with no word moving on either channel before giving up
    localparam int WATCHDOG_LIMIT = 100000;
    // long receiver hold-off used to back the block up
    localparam int HOLD_OFF_CYCLES = 3000;
    // quiet cycles after the last sum
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_NUMBERS = 560;
    localparam int PHASE_COUNT = 3;

    // tracks expected sums in arrival order and checks the block output
    class divisor_sum_tracker;
        logic [SUM_BITS-1:0] pending_sums[$];
        int mismatches;
        int sums_checked;

        function new();
            mismatches = 0;
            sums_checked = 0;
        endfunction

        // sum of all divisors below n, found by pairing divisors up to sqrt(n)
        function automatic logic [SUM_BITS-1:0] proper_sum_of(logic [NUMBER_BITS-1:0] n);
            longint unsigned total;
            longint unsigned d;
            longint unsigned q;
            longint unsigned nn;
            nn = longint'(n);
            if (nn < 2)
                return '0;
            total = 1;
            for (d = 2; d * d <= nn; d++)
            begin
                if (nn % d == 0)
                begin
                    q = nn / d;
                    total += d;
                    if (q != d)
                        total += q;
                end
            end
            return SUM_BITS'(total);
        endfunction

        function void note_number(logic [NUMBER_BITS-1:0] n);
            pending_sums.push_back(proper_sum_of(n));
        endfunction

        function void check_sum(logic [SUM_BITS-1:0] actual);
            logic [SUM_BITS-1:0] expected;
            sums_checked++;
            if (pending_sums.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: sum %0d arrived with nothing expected", actual);
                return;
            end
            expected = pending_sums.pop_front();
            if (actual !== expected)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: divisor_sum expected %0d actual %0d",
                             expected, actual);
            end
        endfunction

        function int pending();
            return pending_sums.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [NUMBER_BITS-1:0] number;
    logic                   out_valid;
    logic                   out_stall;
    logic [SUM_BITS-1:0]    divisor_sum;

    divisor_sum_tracker tracker;

    int send_idle_pct;
    int recv_idle_pct;
    int numbers_sent;
    int quiet_cycles;
    bit hold_off_go;

    proper_divisor_sum dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .number      (number),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .divisor_sum (divisor_sum)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // sample both channels at the rising edge, watchdog on idle traffic
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                tracker.note_number(number);
                numbers_sent++;
            end
            if (out_valid && !out_stall)
                tracker.check_sum(divisor_sum);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", quiet_cycles);
                $display("FAIL proper_divisor_sum");
                $finish;
            end
        end
    end

    // receiver stall, random or held for a long stretch on request
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_go)
            begin
                hold_off_go = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // offer one number, with random gaps ahead of it, until it is taken
    task automatic send_number(input logic [NUMBER_BITS-1:0] n);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        number   <= n;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // mostly small numbers keep run time down, a few span all bits
    function automatic logic [NUMBER_BITS-1:0] random_number();
        int pick;
        pick = $urandom_range(99);
        if (pick < 85)
            return NUMBER_BITS'($urandom_range(1023));
        else if (pick < 97)
            return NUMBER_BITS'($urandom_range(65535));
        else
            return NUMBER_BITS'($urandom());
    endfunction

    initial
    begin : main
        logic [NUMBER_BITS-1:0] edge_values[$];
        int per_phase;
        int ph;
        int k;

        tracker = new();
        numbers_sent = 0;
        quiet_cycles = 0;
        hold_off_go = 1'b0;
        send_idle_pct = 34;
        recv_idle_pct = 73;
        rst_n = 1'b0;
        in_valid = 1'b0;
        number = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero and one, smallest primes, squares, perfect numbers, extremes
        edge_values = '{20'd0, 20'd1, 20'd2, 20'd3, 20'd4, 20'd5, 20'd6, 20'd9,
                        20'd25, 20'd28, 20'd496, 20'd1023, 20'd1024, 20'd8128,
                        20'd65536, 20'd524288, 20'd720720, 20'd1046529,
                        20'h55555, 20'hAAAAA, 20'd1048573, 20'd1048575};
        foreach (edge_values[i])
            send_number(edge_values[i]);

        // three idle mixes; the last one starts with a long output hold-off
        per_phase = RANDOM_NUMBERS / PHASE_COUNT;
        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 34;
                    recv_idle_pct = 73;
                end
                1:
                begin
                    send_idle_pct = 73;
                    recv_idle_pct = 34;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_off_go = 1'b1;
                end
            endcase
            for (k = 0; k < per_phase; k++)
                send_number(random_number());
        end
        in_valid <= 1'b0;

        // let every sum come out, then give the block time to go quiet
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d numbers (edge values, then random under three idle mixes",
                 numbers_sent);
        $display("and one long output hold-off), %0d sums checked, %0d mismatches",
                 tracker.sums_checked, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("PASS proper_divisor_sum");
        else
            $display("FAIL proper_divisor_sum");
        $finish;
    end

endmodule
